// ----- src/fco_pkg.sv -----
// Shared types, codes and constant tables of the fly camera orientation block.
// Used by the controller, the datapath and the top level; depends on nothing.
package fco_pkg;

  // Default fraction widths of the angle and vector formats
  localparam int AF_DEF = 16;
  localparam int VF_DEF = 14;

  // Request kinds
  localparam logic [1:0] REQ_MOVE    = 2'd0;
  localparam logic [1:0] REQ_TURN    = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  // Move keys
  localparam logic [2:0] KEY_W = 3'd0;
  localparam logic [2:0] KEY_S = 3'd1;
  localparam logic [2:0] KEY_A = 3'd2;
  localparam logic [2:0] KEY_D = 3'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_MOVE_SPEED  = 3'd0;
  localparam logic [2:0] CFG_TURN_SPEED  = 3'd1;
  localparam logic [2:0] CFG_START_X     = 3'd2;
  localparam logic [2:0] CFG_START_Y     = 3'd3;
  localparam logic [2:0] CFG_START_Z     = 3'd4;
  localparam logic [2:0] CFG_START_YAW   = 3'd5;
  localparam logic [2:0] CFG_START_PITCH = 3'd6;

  // Configuration reset values
  localparam logic [15:0] MOVE_SPEED_RST = 16'd1280;
  localparam logic [15:0] TURN_SPEED_RST = 16'd410;
  localparam logic [24:0] START_YAW_RST  = 25'd17694720;

  // Fixed-point constants
  localparam logic [31:0] DEG_TO_RAD_Q32 = 32'd74961321;
  localparam logic [31:0] ONE_Q30        = 32'h4000_0000;
  localparam int          DEG_LIM        = 89;

  // Sequencer lengths
  localparam int COS_TERMS = 6;
  localparam int SIN_TERMS = 5;
  localparam int MOD_STEPS = 11;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_RESTART, OP_TURN_X, OP_TURN_Y, OP_TURN_P, OP_MOD, OP_YAW,
    OP_PREP, OP_RAD, OP_SQ, OP_X2, OP_PMUL, OP_DMUL, OP_DCOR, OP_CSAVE, OP_SMUL,
    OP_SFIN, OP_PROD, OP_PSTORE, OP_VEL, OP_VSAVE, OP_MMUL, OP_MADD, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [3:0] idx;
    logic       sel;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic [2:0] key;
  } dp_stat_t;

  // Horner divisors of the Taylor series, innermost first
  function automatic logic [7:0] div_const(input logic is_cos, input logic [3:0] i);
    logic [7:0] d;
    d = 8'd2;
    if (is_cos) begin
      case (i)
        4'd0: d = 8'd132;
        4'd1: d = 8'd90;
        4'd2: d = 8'd56;
        4'd3: d = 8'd30;
        4'd4: d = 8'd12;
        default: d = 8'd2;
      endcase
    end else begin
      case (i)
        4'd0: d = 8'd110;
        4'd1: d = 8'd72;
        4'd2: d = 8'd42;
        4'd3: d = 8'd20;
        default: d = 8'd6;
      endcase
    end
    return d;
  endfunction

  // floor(2^30 / divisor), same indexing as div_const
  function automatic logic [29:0] div_recip(input logic is_cos, input logic [3:0] i);
    logic [29:0] r;
    r = 30'd536870912;
    if (is_cos) begin
      case (i)
        4'd0: r = 30'd8134407;
        4'd1: r = 30'd11930464;
        4'd2: r = 30'd19173961;
        4'd3: r = 30'd35791394;
        4'd4: r = 30'd89478485;
        default: r = 30'd536870912;
      endcase
    end else begin
      case (i)
        4'd0: r = 30'd9761289;
        4'd1: r = 30'd14913080;
        4'd2: r = 30'd25565281;
        4'd3: r = 30'd53687091;
        default: r = 30'd178956970;
      endcase
    end
    return r;
  endfunction

endpackage

// ----- src/fco_ctrl.sv -----
// Sequencer of the fly camera block: walks each request through its micro-steps.
// Depends on fco_pkg; drives fco_dp through dp_cmd_t and reads dp_stat_t.
module fco_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output fco_pkg::dp_cmd_t  cmd,
  input  fco_pkg::dp_stat_t stat
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_VEL, S_VSAVE, S_MMUL, S_MADD, S_TX, S_TY, S_TP, S_RST, S_MOD,
    S_YAW, S_PREP, S_RAD, S_SQ, S_X2, S_PMUL, S_DMUL, S_DCOR, S_CSAVE, S_SMUL,
    S_SFIN, S_PROD, S_PST, S_OUT
  } state_t;

  state_t     state_r;
  logic [3:0] cnt_r;
  logic       ang_r;
  logic       cph_r;
  logic       rdy_r;
  logic       ov_r;
  logic       take;
  logic       emit;

  assign in_ready  = rdy_r;
  assign out_valid = ov_r;
  assign take      = in_valid && rdy_r;
  assign emit      = (state_r == S_OUT) && (!ov_r || out_ready);

  // Decode the step into a datapath command
  always_comb begin
    cmd.idx = cnt_r;
    cmd.sel = 1'b0;
    case (state_r)
      S_IDLE:  cmd.op = take ? fco_pkg::OP_LOAD : fco_pkg::OP_NOP;
      S_VEL:   cmd.op = fco_pkg::OP_VEL;
      S_VSAVE: cmd.op = fco_pkg::OP_VSAVE;
      S_MMUL:  cmd.op = fco_pkg::OP_MMUL;
      S_MADD:  cmd.op = fco_pkg::OP_MADD;
      S_TX:    cmd.op = fco_pkg::OP_TURN_X;
      S_TY:    cmd.op = fco_pkg::OP_TURN_Y;
      S_TP:    cmd.op = fco_pkg::OP_TURN_P;
      S_RST:   cmd.op = fco_pkg::OP_RESTART;
      S_MOD:   cmd.op = fco_pkg::OP_MOD;
      S_YAW:   cmd.op = fco_pkg::OP_YAW;
      S_PREP: begin
        cmd.op  = fco_pkg::OP_PREP;
        cmd.sel = ang_r;
      end
      S_RAD:   cmd.op = fco_pkg::OP_RAD;
      S_SQ:    cmd.op = fco_pkg::OP_SQ;
      S_X2:    cmd.op = fco_pkg::OP_X2;
      S_PMUL:  cmd.op = fco_pkg::OP_PMUL;
      S_DMUL: begin
        cmd.op  = fco_pkg::OP_DMUL;
        cmd.sel = cph_r;
      end
      S_DCOR: begin
        cmd.op  = fco_pkg::OP_DCOR;
        cmd.sel = cph_r;
      end
      S_CSAVE: cmd.op = fco_pkg::OP_CSAVE;
      S_SMUL:  cmd.op = fco_pkg::OP_SMUL;
      S_SFIN: begin
        cmd.op  = fco_pkg::OP_SFIN;
        cmd.sel = ang_r;
      end
      S_PROD:  cmd.op = fco_pkg::OP_PROD;
      S_PST:   cmd.op = fco_pkg::OP_PSTORE;
      S_OUT:   cmd.op = emit ? fco_pkg::OP_OUT : fco_pkg::OP_NOP;
      default: cmd.op = fco_pkg::OP_NOP;
    endcase
  end

  // Advance the sequence; hold the result valid until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ang_r   <= 1'b0;
      cph_r   <= 1'b0;
      rdy_r   <= 1'b1;
      ov_r    <= 1'b0;
    end else begin
      if (ov_r && out_ready && !emit) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (take) begin
            rdy_r   <= 1'b0;
            state_r <= S_DISP;
          end
        end
        S_DISP: begin
          case (stat.req)
            fco_pkg::REQ_MOVE:    state_r <= (stat.key <= fco_pkg::KEY_D) ? S_VEL : S_OUT;
            fco_pkg::REQ_TURN:    state_r <= S_TX;
            fco_pkg::REQ_RESTART: state_r <= S_RST;
            default:              state_r <= S_OUT;
          endcase
        end
        S_VEL: state_r <= S_VSAVE;
        S_VSAVE: begin
          cnt_r   <= '0;
          state_r <= S_MMUL;
        end
        S_MMUL: state_r <= S_MADD;
        S_MADD: begin
          if (cnt_r == 4'd2) begin
            state_r <= S_OUT;
          end else begin
            cnt_r   <= cnt_r + 4'd1;
            state_r <= S_MMUL;
          end
        end
        S_TX: state_r <= S_TY;
        S_TY: state_r <= S_TP;
        S_TP, S_RST: begin
          cnt_r   <= 4'(fco_pkg::MOD_STEPS - 1);
          state_r <= S_MOD;
        end
        S_MOD: begin
          if (cnt_r == 4'd0) state_r <= S_YAW;
          else cnt_r <= cnt_r - 4'd1;
        end
        S_YAW: begin
          ang_r   <= 1'b0;
          state_r <= S_PREP;
        end
        S_PREP: state_r <= S_RAD;
        S_RAD:  state_r <= S_SQ;
        S_SQ:   state_r <= S_X2;
        S_X2: begin
          cph_r   <= 1'b1;
          cnt_r   <= '0;
          state_r <= S_PMUL;
        end
        S_PMUL: state_r <= S_DMUL;
        S_DMUL: state_r <= S_DCOR;
        S_DCOR: begin
          if (cph_r && cnt_r == 4'(fco_pkg::COS_TERMS - 1)) begin
            state_r <= S_CSAVE;
          end else if (!cph_r && cnt_r == 4'(fco_pkg::SIN_TERMS - 1)) begin
            state_r <= S_SMUL;
          end else begin
            cnt_r   <= cnt_r + 4'd1;
            state_r <= S_PMUL;
          end
        end
        S_CSAVE: begin
          cph_r   <= 1'b0;
          cnt_r   <= '0;
          state_r <= S_PMUL;
        end
        S_SMUL: state_r <= S_SFIN;
        S_SFIN: begin
          if (!ang_r) begin
            ang_r   <= 1'b1;
            state_r <= S_PREP;
          end else begin
            cnt_r   <= '0;
            state_r <= S_PROD;
          end
        end
        S_PROD: state_r <= S_PST;
        S_PST: begin
          if (cnt_r == 4'd3) begin
            state_r <= S_OUT;
          end else begin
            cnt_r   <= cnt_r + 4'd1;
            state_r <= S_PROD;
          end
        end
        S_OUT: begin
          if (emit) begin
            ov_r    <= 1'b1;
            rdy_r   <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/fco_dp.sv -----
// Datapath of the fly camera block: camera state, config registers, one shared
// 32x32 multiplier and the step logic. Depends on fco_pkg; driven by fco_ctrl.
module fco_dp #(
  parameter int AF = fco_pkg::AF_DEF,
  parameter int VF = fco_pkg::VF_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fco_pkg::dp_cmd_t   cmd,
  output fco_pkg::dp_stat_t  stat,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [31:0]        cfg_wdata,
  input  logic [1:0]         in_req,
  input  logic [2:0]         in_key,
  input  logic [15:0]        in_dt,
  input  logic [15:0]        in_xc,
  input  logic [15:0]        in_yc,
  output logic [239:0]       out_data
);

  localparam int YAW_W = AF + 9;
  localparam int PIT_W = AF + 8;
  localparam int MAG_W = AF + 20;
  localparam int SUM_W = AF + 22;
  localparam int VW    = VF + 2;

  localparam logic [MAG_W-1:0] Q360 = MAG_W'(360) << AF;
  localparam logic [YAW_W-1:0] Q45  = YAW_W'(45) << AF;
  localparam logic [YAW_W-1:0] Q90  = YAW_W'(90) << AF;
  localparam logic [YAW_W-1:0] Q180 = YAW_W'(180) << AF;
  localparam logic [YAW_W-1:0] Q270 = YAW_W'(270) << AF;
  localparam logic signed [SUM_W-1:0] QS360 = SUM_W'(360) << AF;
  localparam logic signed [SUM_W-1:0] PLIM  = SUM_W'(fco_pkg::DEG_LIM) << AF;
  localparam logic signed [VW-1:0]    VONE  = VW'(1) << VF;
  localparam logic signed [33:0]      PMAX  = 34'sh0_7FFF_FFFF;
  localparam logic signed [33:0]      PMIN  = -34'sh0_8000_0000;

  // Turn counts times speed, rescaled from Q.12 to the angle format, rounded
  function automatic logic [MAG_W-1:0] turn_mag(input logic [31:0] m);
    logic [MAG_W+11:0] w;
    w = ({{AF{1'b0}}, m} << AF) + (MAG_W + 12)'(2048);
    return w[MAG_W+11:12];
  endfunction

  function automatic logic signed [PIT_W-1:0] clamp_pitch(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] c;
    c = v;
    if (v > PLIM) c = PLIM;
    else if (v < -PLIM) c = -PLIM;
    return c[PIT_W-1:0];
  endfunction

  // Round a signed Q30 value to the vector format, half away from zero
  function automatic logic signed [VW-1:0] to_vec(input logic signed [31:0] v);
    logic [31:0]    mag;
    logic [31:0]    r;
    logic [VW-1:0]  m;
    mag = v[31] ? 32'(-v) : 32'(v);
    r   = (mag + (32'd1 << (29 - VF))) >> (30 - VF);
    m   = r[VW-1:0];
    return v[31] ? $signed(-m) : $signed(m);
  endfunction

  // Configuration
  logic [15:0]        move_speed_r, turn_speed_r;
  logic signed [31:0] start_x_r, start_y_r, start_z_r;
  logic [24:0]        start_yaw_r;
  logic signed [23:0] start_pitch_r;

  // Camera state
  logic signed [31:0]      pos_r   [3];
  logic [YAW_W-1:0]        yaw_r;
  logic signed [PIT_W-1:0] pit_r;
  logic signed [VW-1:0]    front_r [3];
  logic signed [VW-1:0]    right_r [3];
  logic signed [VW-1:0]    up_r    [3];

  // Working registers
  logic [1:0]         req_r;
  logic [2:0]         key_r;
  logic [15:0]        dt_r;
  logic signed [15:0] xc_r, yc_r;
  logic [63:0]        prod_r;
  logic [MAG_W-1:0]   rem_r;
  logic               dneg_r;
  logic [1:0]         quad_r;
  logic               swap_r;
  logic [31:0]        x_r, x2_r, p_r, n_r, cpoly_r, vel_r;
  logic signed [31:0] sy_r, cy_r, sp_r, cp_r;
  logic               psign_r;
  logic               mneg_r;
  logic [239:0]       out_data_r;

  // Combinational step values
  logic [31:0]             mul_a, mul_b;
  logic [16:0]             xmag, ymag;
  logic [YAW_W-1:0]        pabs, ang_in, ang_r2, ang_red;
  logic [1:0]              quad;
  logic [MAG_W-1:0]        mod_sub;
  logic signed [SUM_W-1:0] yaw_sum, pit_sum;
  logic [MAG_W-1:0]        dpm;
  logic [31:0]             qe;
  logic [39:0]             qrem;
  logic [31:0]             qfix;
  logic [31:0]             spoly;
  logic signed [31:0]      s0, c0, s_q, c_q;
  logic signed [31:0]      pa, pb;
  logic [31:0]             pa_m, pb_m;
  logic [31:0]             prnd;
  logic signed [31:0]      pq30;
  logic signed [VW-1:0]    vsel;
  logic [VW-1:0]           vmag;
  logic                    vneg;
  logic [63:0]             dwide;
  logic signed [33:0]      dsig, psum;
  logic [1:0]              vi;

  assign stat.req = req_r;
  assign stat.key = key_r;
  assign out_data = out_data_r;
  assign vi       = cmd.idx[1:0];

  // Operand magnitudes and pitch magnitude
  always_comb begin
    xmag = xc_r[15] ? (17'd0 - {xc_r[15], xc_r}) : {1'b0, xc_r};
    ymag = yc_r[15] ? (17'd0 - {yc_r[15], yc_r}) : {1'b0, yc_r};
    pabs = pit_r[PIT_W-1] ? {1'b0, PIT_W'(-pit_r)} : {1'b0, PIT_W'(pit_r)};
  end

  // Reduce an angle to a quadrant and an offset of at most 45 degrees
  always_comb begin
    ang_in = cmd.sel ? pabs : yaw_r;
    if (ang_in >= Q270) begin
      quad   = 2'd3;
      ang_r2 = ang_in - Q270;
    end else if (ang_in >= Q180) begin
      quad   = 2'd2;
      ang_r2 = ang_in - Q180;
    end else if (ang_in >= Q90) begin
      quad   = 2'd1;
      ang_r2 = ang_in - Q90;
    end else begin
      quad   = 2'd0;
      ang_r2 = ang_in;
    end
    ang_red = (ang_r2 > Q45) ? (Q90 - ang_r2) : ang_r2;
  end

  // Turn and wrap arithmetic
  always_comb begin
    mod_sub = Q360 << cmd.idx;
    yaw_sum = $signed({{(SUM_W - YAW_W){1'b0}}, yaw_r})
              + (dneg_r ? -$signed({2'b00, rem_r}) : $signed({2'b00, rem_r}));
    if (yaw_sum >= QS360) yaw_sum = yaw_sum - QS360;
    else if (yaw_sum < 0) yaw_sum = yaw_sum + QS360;
    dpm     = turn_mag(prod_r[31:0]);
    pit_sum = SUM_W'(pit_r)
              + (yc_r[15] ? -$signed({2'b00, dpm}) : $signed({2'b00, dpm}));
  end

  // Divide-by-constant correction and quadrant mapping
  always_comb begin
    qe    = prod_r[61:30];
    qrem  = {8'd0, n_r} - qe * fco_pkg::div_const(cmd.sel, cmd.idx);
    qfix  = (qrem >= 40'(fco_pkg::div_const(cmd.sel, cmd.idx))) ? qe + 32'd1 : qe;
    spoly = prod_r[61:30];
    s0    = swap_r ? $signed(cpoly_r) : $signed(spoly);
    c0    = swap_r ? $signed(spoly) : $signed(cpoly_r);
    case (quad_r)
      2'd0: begin
        s_q = s0;
        c_q = c0;
      end
      2'd1: begin
        s_q = c0;
        c_q = -s0;
      end
      2'd2: begin
        s_q = -s0;
        c_q = -c0;
      end
      default: begin
        s_q = -c0;
        c_q = s0;
      end
    endcase
  end

  // Basis products: (cy,cp) (sy,cp) and negated (cy,sp) (sy,sp)
  always_comb begin
    pa   = cmd.idx[0] ? sy_r : cy_r;
    pb   = cmd.idx[1] ? sp_r : cp_r;
    pa_m = pa[31] ? 32'(-pa) : 32'(pa);
    pb_m = pb[31] ? 32'(-pb) : 32'(pb);
    prnd = 32'((prod_r + 64'h2000_0000) >> 30);
    pq30 = psign_r ? -$signed(prnd) : $signed(prnd);
  end

  // Move displacement along the chosen vector
  always_comb begin
    vsel  = (key_r == fco_pkg::KEY_W || key_r == fco_pkg::KEY_S) ? front_r[vi] : right_r[vi];
    vmag  = vsel[VW-1] ? VW'(-vsel) : VW'(vsel);
    vneg  = vsel[VW-1] ^ (key_r == fco_pkg::KEY_S || key_r == fco_pkg::KEY_A);
    dwide = (prod_r + (64'd1 << (VF + 7))) >> (VF + 8);
    dsig  = mneg_r ? -$signed(dwide[33:0]) : $signed(dwide[33:0]);
    psum  = 34'(pos_r[vi]) + dsig;
    if (psum > PMAX) psum = PMAX;
    else if (psum < PMIN) psum = PMIN;
  end

  // Select the shared multiplier's operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      fco_pkg::OP_TURN_X: begin
        mul_a = 32'(xmag);
        mul_b = 32'(turn_speed_r);
      end
      fco_pkg::OP_TURN_Y: begin
        mul_a = 32'(ymag);
        mul_b = 32'(turn_speed_r);
      end
      fco_pkg::OP_PREP: begin
        mul_a = 32'(ang_red);
        mul_b = fco_pkg::DEG_TO_RAD_Q32;
      end
      fco_pkg::OP_SQ: begin
        mul_a = x_r;
        mul_b = x_r;
      end
      fco_pkg::OP_PMUL: begin
        mul_a = x2_r;
        mul_b = p_r;
      end
      fco_pkg::OP_DMUL: begin
        mul_a = prod_r[61:30];
        mul_b = 32'(fco_pkg::div_recip(cmd.sel, cmd.idx));
      end
      fco_pkg::OP_SMUL: begin
        mul_a = x_r;
        mul_b = p_r;
      end
      fco_pkg::OP_PROD: begin
        mul_a = pa_m;
        mul_b = pb_m;
      end
      fco_pkg::OP_VEL: begin
        mul_a = 32'(move_speed_r);
        mul_b = 32'(dt_r);
      end
      fco_pkg::OP_MMUL: begin
        mul_a = 32'(vmag);
        mul_b = vel_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Config writes and camera state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_speed_r  <= fco_pkg::MOVE_SPEED_RST;
      turn_speed_r  <= fco_pkg::TURN_SPEED_RST;
      start_x_r     <= '0;
      start_y_r     <= '0;
      start_z_r     <= '0;
      start_yaw_r   <= fco_pkg::START_YAW_RST;
      start_pitch_r <= '0;
      pos_r[0]      <= '0;
      pos_r[1]      <= '0;
      pos_r[2]      <= '0;
      yaw_r         <= Q270;
      pit_r         <= '0;
      front_r[0]    <= '0;
      front_r[1]    <= '0;
      front_r[2]    <= -VONE;
      right_r[0]    <= VONE;
      right_r[1]    <= '0;
      right_r[2]    <= '0;
      up_r[0]       <= '0;
      up_r[1]       <= VONE;
      up_r[2]       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          fco_pkg::CFG_MOVE_SPEED:  move_speed_r  <= cfg_wdata[15:0];
          fco_pkg::CFG_TURN_SPEED:  turn_speed_r  <= cfg_wdata[15:0];
          fco_pkg::CFG_START_X:     start_x_r     <= cfg_wdata;
          fco_pkg::CFG_START_Y:     start_y_r     <= cfg_wdata;
          fco_pkg::CFG_START_Z:     start_z_r     <= cfg_wdata;
          fco_pkg::CFG_START_YAW:   start_yaw_r   <= cfg_wdata[24:0];
          fco_pkg::CFG_START_PITCH: start_pitch_r <= cfg_wdata[23:0];
          default: ;
        endcase
      end
      case (cmd.op)
        fco_pkg::OP_RESTART: begin
          pos_r[0] <= start_x_r;
          pos_r[1] <= start_y_r;
          pos_r[2] <= start_z_r;
          pit_r    <= clamp_pitch(SUM_W'(start_pitch_r));
        end
        fco_pkg::OP_TURN_P: pit_r <= clamp_pitch(pit_sum);
        fco_pkg::OP_YAW: begin
          if (req_r == fco_pkg::REQ_TURN) yaw_r <= yaw_sum[YAW_W-1:0];
          else yaw_r <= rem_r[YAW_W-1:0];
        end
        fco_pkg::OP_PSTORE: begin
          case (vi)
            2'd0:    front_r[0] <= to_vec(pq30);
            2'd1:    front_r[2] <= to_vec(pq30);
            2'd2:    up_r[0]    <= to_vec(pq30);
            default: up_r[2]    <= to_vec(pq30);
          endcase
          front_r[1] <= to_vec(sp_r);
          right_r[0] <= to_vec(-sy_r);
          right_r[1] <= '0;
          right_r[2] <= to_vec(cy_r);
          up_r[1]    <= to_vec(cp_r);
        end
        fco_pkg::OP_MADD: pos_r[vi] <= psum[31:0];
        default: ;
      endcase
    end
  end

  // Working registers of the sequence
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (cmd.op)
      fco_pkg::OP_LOAD: begin
        req_r <= in_req;
        key_r <= in_key;
        dt_r  <= in_dt;
        xc_r  <= in_xc;
        yc_r  <= in_yc;
      end
      fco_pkg::OP_RESTART: rem_r <= MAG_W'(start_yaw_r);
      fco_pkg::OP_TURN_Y: begin
        rem_r  <= turn_mag(prod_r[31:0]);
        dneg_r <= xc_r[15];
      end
      fco_pkg::OP_MOD: if (rem_r >= mod_sub) rem_r <= rem_r - mod_sub;
      fco_pkg::OP_PREP: begin
        quad_r <= quad;
        swap_r <= ang_r2 > Q45;
      end
      fco_pkg::OP_RAD: x_r <= 32'((prod_r + (64'd1 << (AF + 1))) >> (AF + 2));
      fco_pkg::OP_X2: begin
        x2_r <= prod_r[61:30];
        p_r  <= fco_pkg::ONE_Q30;
      end
      fco_pkg::OP_DMUL: n_r <= prod_r[61:30];
      fco_pkg::OP_DCOR: p_r <= fco_pkg::ONE_Q30 - qfix;
      fco_pkg::OP_CSAVE: begin
        cpoly_r <= p_r;
        p_r     <= fco_pkg::ONE_Q30;
      end
      fco_pkg::OP_SFIN: begin
        if (cmd.sel) begin
          sp_r <= pit_r[PIT_W-1] ? -s_q : s_q;
          cp_r <= c_q;
        end else begin
          sy_r <= s_q;
          cy_r <= c_q;
        end
      end
      fco_pkg::OP_PROD: psign_r <= pa[31] ^ pb[31] ^ vi[1];
      fco_pkg::OP_VSAVE: vel_r <= prod_r[31:0];
      fco_pkg::OP_MMUL: mneg_r <= vneg;
      fco_pkg::OP_OUT: begin
        out_data_r <= {16'(up_r[2]), 16'(up_r[1]), 16'(up_r[0]),
                       16'(right_r[2]), 16'(right_r[1]), 16'(right_r[0]),
                       16'(front_r[2]), 16'(front_r[1]), 16'(front_r[0]),
                       pos_r[2], pos_r[1], pos_r[0]};
      end
      default: ;
    endcase
  end

endmodule

// ----- src/fly_camera_orientation.sv -----
// Top level of the yaw/pitch fly camera block: ports, field unpacking, checks.
// Depends on fco_pkg, fco_ctrl and fco_dp.
//
// Usage: each request on the in_ channel is a move step, a mouse turn or a
// restart (in_tuser); every request yields one result on the out_ channel with
// the camera position and its front, right and up unit vectors after it.
// Configuration writes go through cfg_valid/cfg_index/cfg_data, always ready;
// the user must make them only while no request is in flight, as the block
// itself does not enforce it. A move without a valid key and an unused code go
// straight to the result. The time a request takes is set by the single shared
// 32x32 multiplier: each Taylor term of sin and cos takes two passes through it
// and a correction step, and the yaw wrap takes an 11-step subtractor.
// One request is worked at a time; a new one is taken as soon as the previous
// result sits in the output register.
// Reset: synchronous, active low; position 0, yaw 270 degrees, pitch 0 and the
// matching basis; the start and speed registers take their reset values.
// A stalled receiver holds the result in the output register; the next request
// is worked and then waits for that register to empty.
module fly_camera_orientation #(
  parameter int ANGLE_FRAC_BITS = fco_pkg::AF_DEF,
  parameter int VEC_FRAC_BITS   = fco_pkg::VF_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [2:0] key_dir, [18:3] delta_time, [34:19] x_change, [50:35] y_change, rest zero
  input  logic [55:0]  in_tdata,
  // [1:0] req_type
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z, [111:96] front_x, [127:112] front_y,
  // [143:128] front_z, [159:144] right_x, [175:160] right_y, [191:176] right_z,
  // [207:192] up_x, [223:208] up_y, [239:224] up_z
  output logic [239:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  fco_pkg::dp_cmd_t  cmd;
  fco_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  fco_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  fco_dp #(
    .AF (ANGLE_FRAC_BITS),
    .VF (VEC_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .in_req    (in_tuser),
    .in_key    (in_tdata[2:0]),
    .in_dt     (in_tdata[18:3]),
    .in_xc     (in_tdata[34:19]),
    .in_yc     (in_tdata[50:35]),
    .out_data  (out_tdata)
  );

  // A request is worked alone: no second accept right after one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while busy");

  // No result can appear in the cycle right after an accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result raised too early");

endmodule
